[sv/chunked_substring_match_assert.svh]
// assertion helpers used by the asserting file
`ifndef CHUNKED_SUBSTRING_MATCH_ASSERT_SVH
`define CHUNKED_SUBSTRING_MATCH_ASSERT_SVH

// same-cycle implication
`define CSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csm: implication check failed");

// next-cycle implication
`define CSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csm: next-cycle check failed");

`endif

[sv/csm_pkg.sv]
`default_nettype none
package csm_pkg;
   localparam int PATTERN_MAX = 16;
   localparam int CHUNK_SPAN = 128;
   localparam int OFFSET_W = $clog2(CHUNK_SPAN);
   localparam int LENGTH_W = 5;
   localparam int CNT_W = (OFFSET_W > LENGTH_W) ? OFFSET_W : LENGTH_W;
   localparam int CHUNK_NUMBER_W = 25;
   localparam int POSITION_W = 32;
   localparam int WORD_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_LENGTH       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_MAX-1:0][7:0] pattern;
      logic [LENGTH_W-1:0]         length;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [POSITION_W-1:0] position;
   } result_type;
endpackage
`default_nettype wire

[sv/csm_match_core.sv]
`default_nettype none
module csm_match_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        text_byte,
   input  wire logic              file_start,
   input  wire csm_pkg::cfg_type  cfg,
   output csm_pkg::result_type    push,
   output logic                   match_seen
);
   localparam int PM = csm_pkg::PATTERN_MAX;

   logic [7:0] window_ff [PM-1];
   logic [7:0] window_in [PM-1];
   logic [csm_pkg::OFFSET_W-1:0] offset_ff, offset_in, offset_cur;
   logic [csm_pkg::CHUNK_NUMBER_W-1:0] chunk_ff, chunk_in, chunk_cur;
   logic seen_ff, seen_in, seen_cur;

   logic [7:0] win [PM];
   logic [csm_pkg::OFFSET_W-1:0] count;
   logic [csm_pkg::LENGTH_W-1:0] len_eff;
   logic [PM:0] hit_by_len;
   logic hit, chunk_end;
   logic [csm_pkg::POSITION_W-1:0] position;

   // a file start clears the search state before this byte is taken
   assign seen_cur   = file_start ? 1'b0 : seen_ff;
   assign offset_cur = file_start ? '0 : offset_ff;
   assign chunk_cur  = file_start ? '0 : chunk_ff;
   assign count      = offset_cur + 1'b1;

   assign len_eff = (cfg.length > csm_pkg::LENGTH_W'(PM)) ?
                    csm_pkg::LENGTH_W'(PM) : cfg.length;

   always_comb begin
      win[0] = text_byte;
      for (int j = 1; j < PM; j++) begin
         win[j] = window_ff[j-1];
      end
   end

   // newest byte lines up with the last pattern byte for every length
   always_comb begin
      logic m;
      hit_by_len[0] = 1'b0;
      for (int l = 1; l <= PM; l++) begin
         m = 1'b1;
         for (int k = 0; k < l; k++) begin
            m = m & (win[l-1-k] == cfg.pattern[k]);
         end
         hit_by_len[l] = m;
      end
   end

   assign hit = hit_by_len[len_eff] &&
                (csm_pkg::CNT_W'(count) >= csm_pkg::CNT_W'(len_eff));

   assign position = csm_pkg::POSITION_W'(chunk_cur * csm_pkg::CHUNK_SPAN) +
                     csm_pkg::POSITION_W'(csm_pkg::CNT_W'(count) -
                                          csm_pkg::CNT_W'(len_eff));

   assign chunk_end = (text_byte == csm_pkg::NEWLINE_BYTE) ||
                      (count >= csm_pkg::OFFSET_W'(csm_pkg::CHUNK_SPAN - 1));

   always_comb begin
      for (int j = 0; j < PM - 1; j++) begin
         window_in[j] = win[j];
      end
      seen_in = hit;
      if (chunk_end) begin
         offset_in = '0;
         chunk_in  = (chunk_cur == '1) ? chunk_cur : chunk_cur + 1'b1;
      end else begin
         offset_in = count;
         chunk_in  = chunk_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !seen_cur) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         chunk_ff  <= '0;
         seen_ff   <= 1'b0;
      end else if (accept) begin
         if (!seen_cur) begin
            offset_ff <= offset_in;
            chunk_ff  <= chunk_in;
            seen_ff   <= seen_in;
         end
      end
   end

   assign push.valid    = accept && !seen_cur && hit;
   assign push.position = position;
   assign match_seen    = seen_ff;
endmodule
`default_nettype wire

[sv/chunked_substring_match.sv]
// chunked_substring_match: first-occurrence search of a configured pattern
// in a byte stream cut into chunks (a chunk ends after a newline or after
// 127 bytes; matches never cross a chunk boundary).
// req channel: one text byte per transfer, req_file_start marks the first
// byte of a new file and clears the chunk counters and the match flag.
// rsp channel: at most one transfer per file, carrying chunk number * 128
// plus the match start offset in the chunk.
// csr port: pattern low/high words and the pattern length; the user must
// write them only while the block is idle, which the block does not
// enforce; a length of zero disables matching.
// throughput: one byte per cycle while req_stall is low; the window compare
// of all pattern lengths is done in parallel in the cycle of the transfer.
// an output register plus one skid register hold results; req_stall is high
// only while the skid register is full, i.e. two results wait on a stalled
// receiver.
// reset clears the pattern registers, search state and both result slots.
`default_nettype none
module chunked_substring_match (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_text_byte,
   input  wire logic                               req_file_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [csm_pkg::POSITION_W-1:0]          rsp_match_position,
   input  wire logic                               csr_write_enable,
   input  wire logic [csm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [csm_pkg::WORD_W-1:0]         csr_write_data
);
   logic [csm_pkg::WORD_W-1:0] pat_low_ff, pat_high_ff;
   logic [csm_pkg::LENGTH_W-1:0] length_ff;
   csm_pkg::cfg_type cfg;
   csm_pkg::result_type push;
   logic match_seen;
   logic accept;

   logic rsp_valid_ff, rsp_valid_in;
   logic [csm_pkg::POSITION_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic skid_valid_ff, skid_valid_in;
   logic [csm_pkg::POSITION_W-1:0] skid_pos_ff, skid_pos_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         length_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            csm_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
            csm_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_write_data;
            csm_pkg::CSR_LENGTH:
               length_ff <= csr_write_data[csm_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.pattern = {pat_high_ff, pat_low_ff};
   assign cfg.length  = length_ff;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   csm_match_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .file_start (req_file_start),
      .cfg        (cfg),
      .push       (push),
      .match_seen (match_seen)
   );

   // output register with one skid slot behind it
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_pos_in    = rsp_pos_ff;
      skid_valid_in = skid_valid_ff;
      skid_pos_in   = skid_pos_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_pos_in    = skid_pos_ff;
            skid_valid_in = push.valid;
            skid_pos_in   = push.position;
         end else begin
            rsp_valid_in = push.valid;
            rsp_pos_in   = push.position;
         end
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_pos_in   = push.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      skid_pos_ff <= skid_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_position = rsp_pos_ff;

`include "chunked_substring_match_assert.svh"

   `CSM_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `CSM_ASSERT_NEXT(a_seen_after_hit, clock, reset, push.valid, match_seen)
   `CSM_ASSERT_IMPLY(a_one_hit_per_file, clock, reset, match_seen && !(accept && req_file_start), !push.valid)
endmodule
`default_nettype wire

[tb/chunked_substring_match_test.sv]
`timescale 1ns / 1ps
module chunked_substring_match_test;

   localparam int ITEM_GOAL = 1400;
   localparam int PHASES = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int IDLE_PCT = 34;

   class substring_tracker;
      logic [csm_pkg::PATTERN_MAX-1:0][7:0] pattern_bytes;
      logic [csm_pkg::LENGTH_W-1:0]         pattern_length;
      logic [7:0]                           window [csm_pkg::PATTERN_MAX];
      logic [csm_pkg::OFFSET_W-1:0]         chunk_offset;
      logic [csm_pkg::CHUNK_NUMBER_W-1:0]   chunk_count;
      bit                                   match_seen;
      logic [csm_pkg::POSITION_W-1:0]       expected_positions [$];
      int                                   mismatches;

      function new();
         pattern_bytes = '0;
         pattern_length = '0;
         mismatches = 0;
         clear_search();
      endfunction

      function void clear_search();
         foreach (window[k]) window[k] = 8'h00;
         chunk_offset = '0;
         chunk_count = '0;
         match_seen = 1'b0;
      endfunction

      function void write_register(csm_pkg::csr_index_type index,
                                   logic [csm_pkg::WORD_W-1:0] data);
         case (index)
            csm_pkg::CSR_PATTERN_LOW: begin
               pattern_bytes[7:0] = data;
            end
            csm_pkg::CSR_PATTERN_HIGH: begin
               pattern_bytes[15:8] = data;
            end
            csm_pkg::CSR_LENGTH: begin
               pattern_length = data[csm_pkg::LENGTH_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // returns 1 when the byte was searched, 0 when it was skipped after a match
      function bit note_text_byte(logic [7:0] text, logic file_start);
         int unsigned                    taken;
         int unsigned                    used;
         bit                             hit;
         logic [csm_pkg::POSITION_W-1:0] position;
         if (file_start) clear_search();
         if (match_seen) return 1'b0;
         for (int k = csm_pkg::PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = text;
         taken = chunk_offset + 1;
         used = (pattern_length > csm_pkg::PATTERN_MAX) ? csm_pkg::PATTERN_MAX
                                                        : pattern_length;
         hit = (used != 0) && (taken >= used);
         for (int k = 0; k < used && hit; k++) begin
            if (window[used-1-k] != pattern_bytes[k]) hit = 1'b0;
         end
         if (hit) begin
            position = csm_pkg::POSITION_W'(chunk_count) * csm_pkg::CHUNK_SPAN +
                       (taken - used);
            expected_positions.push_back(position);
            match_seen = 1'b1;
         end
         if (text == csm_pkg::NEWLINE_BYTE || taken >= csm_pkg::CHUNK_SPAN - 1) begin
            chunk_offset = '0;
            if (chunk_count != '1) chunk_count++;
         end else begin
            chunk_offset = csm_pkg::OFFSET_W'(taken);
         end
         return 1'b1;
      endfunction

      function void check_position(logic [csm_pkg::POSITION_W-1:0] actual);
         logic [csm_pkg::POSITION_W-1:0] wanted;
         if (expected_positions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("match position %0d reported with none expected", actual);
         end else begin
            wanted = expected_positions.pop_front();
            if (actual !== wanted) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("match position: expected %0d, actual %0d", wanted, actual);
            end
         end
      endfunction

      function int pending();
         return expected_positions.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_text_byte = 8'h00;
   logic                           req_file_start = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [csm_pkg::POSITION_W-1:0] rsp_match_position;
   logic                           csr_write_enable = 1'b0;
   csm_pkg::csr_index_type         csr_index = csm_pkg::CSR_PATTERN_LOW;
   logic [csm_pkg::WORD_W-1:0]     csr_write_data = '0;

   substring_tracker                     tracker = new();
   bit                                   steady = 1'b0;
   int                                   taken_items = 0;
   logic [csm_pkg::PATTERN_MAX-1:0][7:0] phase_pattern = '0;
   int                                   phase_eff = 0;

   chunked_substring_match i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_file_start     (req_file_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_position (rsp_match_position),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_position(rsp_match_position);
   end

   task automatic send_text(input logic [7:0] text, input logic file_start);
      int gap;
      gap = 0;
      @(negedge clock);
      while (!steady && gap < 12 && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         req_text_byte = 8'($urandom_range(255));
         req_file_start = 1'($urandom_range(1));
         gap++;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_text_byte = text;
      req_file_start = file_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tracker.note_text_byte(text, file_start)) taken_items++;
   endtask

   // drain every pending match, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [csm_pkg::WORD_W-1:0] low_word,
                            input logic [csm_pkg::WORD_W-1:0] high_word,
                            input logic [csm_pkg::LENGTH_W-1:0] length);
      csm_pkg::csr_index_type     order [3];
      logic [csm_pkg::WORD_W-1:0] words [3];
      logic [csm_pkg::WORD_W-1:0] noise;
      order[0] = csm_pkg::CSR_PATTERN_LOW;
      order[1] = csm_pkg::CSR_PATTERN_HIGH;
      order[2] = csm_pkg::CSR_LENGTH;
      words[0] = low_word;
      words[1] = high_word;
      // upper bits of the length word are don't-care
      noise = {$urandom, $urandom};
      words[2] = {noise[csm_pkg::WORD_W-1:csm_pkg::LENGTH_W], length};
      settle();
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_write_enable = 1'b1;
         csr_index = order[i];
         csr_write_data = words[i];
         @(posedge clock);
         tracker.write_register(order[i], words[i]);
      end
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [7:0] pick_byte(int newline_pct);
      int r;
      r = $urandom_range(99);
      if (r < newline_pct) return csm_pkg::NEWLINE_BYTE;
      if (r < 55 && phase_eff > 0) return phase_pattern[$urandom_range(phase_eff - 1)];
      return 8'($urandom_range(255));
   endfunction

   initial begin
      int                           body_len;
      int                           newline_pct;
      int                           r;
      int                           cut;
      int                           file_pos;
      logic [csm_pkg::LENGTH_W-1:0] length;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset config: zero length, nothing may match
      send_text(8'h00, 1'b1);
      send_text(8'h00, 1'b0);
      send_text(csm_pkg::NEWLINE_BYTE, 1'b0);
      // single zero byte pattern, then bytes after the match are skipped
      configure('0, '0, 5'd1);
      send_text(8'hFF, 1'b1);
      send_text(8'h00, 1'b0);
      send_text(8'h00, 1'b0);
      // overlong length clamps to the full sixteen bytes
      configure('1, '1, 5'd31);
      send_text(8'hFF, 1'b1);
      repeat (15) send_text(8'hFF, 1'b0);
      // pattern straddling a newline cannot fit in one chunk
      configure(64'h410A, '0, 5'd2);
      send_text(csm_pkg::NEWLINE_BYTE, 1'b1);
      send_text(8'h41, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: length = 5'd16;
            1: length = 5'd31;
            2: length = 5'd1;
            default: begin
               length = ($urandom_range(99) < 80) ? 5'($urandom_range(2, 6))
                                                  : 5'($urandom_range(7, 20));
            end
         endcase
         phase_eff = (length > csm_pkg::PATTERN_MAX) ? csm_pkg::PATTERN_MAX : length;
         phase_pattern = {$urandom, $urandom, $urandom, $urandom};
         for (int k = 0; k < phase_eff; k++) begin
            r = $urandom_range(99);
            if (r < 5) phase_pattern[k] = csm_pkg::NEWLINE_BYTE;
            else if (r < 50) phase_pattern[k] = 8'h61 + 8'($urandom_range(2));
            else if (r < 60) phase_pattern[k] = 8'h00;
            else if (r < 70) phase_pattern[k] = 8'hFF;
            else phase_pattern[k] = 8'($urandom_range(255));
         end
         configure(phase_pattern[7:0], phase_pattern[15:8], length);
         steady = (phase == 3);

         while (taken_items < (phase + 1) * ITEM_GOAL / PHASES) begin
            // mostly short files; a few long ones run past the chunk size
            if ($urandom_range(99) < 10) begin
               body_len = $urandom_range(150, 400);
               newline_pct = 0;
            end else begin
               body_len = $urandom_range(4, 40);
               newline_pct = 8;
            end
            send_text(pick_byte(newline_pct), 1'b1);
            file_pos = 1;
            while (file_pos < body_len) begin
               r = $urandom_range(99);
               if (r < 12) begin
                  for (int k = 0; k < phase_eff; k++) send_text(phase_pattern[k], 1'b0);
               end else if (r < 22 && phase_eff > 0) begin
                  // broken copy: a prefix then one flipped bit
                  cut = $urandom_range(phase_eff - 1);
                  for (int k = 0; k < cut; k++) send_text(phase_pattern[k], 1'b0);
                  send_text(phase_pattern[cut] ^ (8'h01 << $urandom_range(7)), 1'b0);
               end else begin
                  send_text(pick_byte(newline_pct), 1'b0);
               end
               file_pos++;
               if (tracker.match_seen && $urandom_range(99) < 70) break;
            end
         end
      end

      settle();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("chunked_substring_match_test OK");
      end else begin
         $display("chunked_substring_match_test NOT OK");
      end
      $finish;
   end

   // cycles without reset, a CSR write or a transfer on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             csr_write_enable)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("chunked_substring_match_test NOT OK");
      $finish;
   end
endmodule
